/* src/plse_pkg.sv */
// Shared types and constants for the packet latency statistics engine.
package plse_pkg;

   // Defaults for the top-level parameters
   localparam int INTERFACES_DEF = 256;
   localparam int BUCKETS_DEF    = 16;

   // Nanoseconds per histogram microsecond
   localparam logic [63:0] NS_PER_US = 64'd1000;

   // Hook kinds carried in the op field
   typedef enum logic [1:0] {
      HOOK_XDP    = 2'd0,
      HOOK_TC_IN  = 2'd1,
      HOOK_TC_OUT = 2'd2
   } hook_kind_type;

   // One packet event
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  interface_index;
      logic [15:0] packet_length;
      logic [47:0] latency;
      logic        matched;
   } req_type;

   // One result word
   typedef struct packed {
      logic [3:0]  bucket;
      logic [63:0] bucket_count;
      logic [63:0] if_packet_count;
      logic [63:0] if_byte_count;
      logic [63:0] if_latency_sum;
      logic [63:0] if_latency_least;
      logic [63:0] if_latency_most;
      logic [63:0] if_hook_count;
      logic [63:0] all_packet_count;
      logic [63:0] all_latency_sum;
   } rsp_type;

   // One row of the per-interface table
   typedef struct packed {
      logic        present;
      logic [63:0] packets;
      logic [63:0] bytes;
      logic [63:0] lat_sum;
      logic [63:0] lat_min;
      logic [63:0] lat_max;
      logic [63:0] xdp_count;
      logic [63:0] tc_in_count;
      logic [63:0] tc_out_count;
   } row_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_BIN,
      ST_UPDATE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic lookup;
      logic bin;
      logic update;
      logic clear_write;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

/* src/packet_latency_stats_engine.sv */
// Top level of the packet latency statistics engine.
//
// Usage: drive one packet event word on req_data and raise start; the word
// is taken at a clock edge where start is high and busy is low. Each event
// yields exactly one result word on rsp_data, marked by rsp_valid for one
// cycle; the receiver has no way to hold it off.
// The result passes through the table read, the bucket encode and the update,
// and is then shown from the result register.
// The sequencer walks lookup, bin and update before it returns to idle, so the
// table row is written back before the next event reads it.
// busy drops while the result is shown, so the next event overlaps it.
// Reset: the histogram and global totals clear at once; the interface table
// is then swept clear one row per cycle, with busy held high throughout.
module packet_latency_stats_engine
   import plse_pkg::*;
#(
   parameter int INTERFACES = INTERFACES_DEF,
   parameter int BUCKETS    = BUCKETS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   plse_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   plse_dp #(
      .INTERFACES (INTERFACES),
      .BUCKETS    (BUCKETS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* src/plse_ctrl.sv */
// Sequencer for the packet latency statistics engine.
module plse_ctrl
   import plse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: state_in = ST_BIN;
         ST_BIN:    state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      busy = 1'b1;
      cmd  = '0;
      case (state_ff)
         ST_CLEAR: cmd.clear_write = 1'b1;
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_LOOKUP: cmd.lookup = 1'b1;
         ST_BIN:    cmd.bin    = 1'b1;
         ST_UPDATE: cmd.update = 1'b1;
         default:   cmd        = '0;
      endcase
   end

endmodule

/* src/plse_dp.sv */
// Datapath: interface table memory, histogram, global totals and result register.
module plse_dp
   import plse_pkg::*;
#(
   parameter int INTERFACES = INTERFACES_DEF,
   parameter int BUCKETS    = BUCKETS_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req_data,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int AW = $clog2(INTERFACES);
   localparam int BW = $clog2(BUCKETS);
   localparam int TW = BUCKETS - 1;

   req_type          req_ff;
   row_type          mem [INTERFACES];
   row_type          rd_ff;
   logic [AW-1:0]    clr_ff;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    wr_addr;
   logic             wr_en;
   row_type          wr_row;
   logic [TW-1:0]    therm_ff;
   logic [TW-1:0]    therm_in;
   logic [BW-1:0]    bkt_ff;
   logic [BW-1:0]    bkt_in;
   logic [63:0]      hist_ff [BUCKETS];
   logic [63:0]      gpkt_ff;
   logic [63:0]      glat_ff;
   logic [63:0]      hist_in;
   logic [63:0]      gpkt_in;
   logic [63:0]      glat_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             rsp_valid_ff;
   logic             in_range;
   logic [63:0]      lat;
   logic             lat_nz;
   row_type          base;
   row_type          row_in;
   logic [63:0]      hook;

   // Event capture
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
   end

   // Clearing sweep address
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_write) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   assign status.clear_last = (clr_ff == AW'(INTERFACES - 1));

   // Table memory: one write port, registered read
   assign rd_addr = AW'(req_ff.interface_index);
   assign in_range = (32'(req_ff.interface_index) < 32'(INTERFACES));
   assign wr_en    = cmd.clear_write || (cmd.update && in_range);
   assign wr_addr  = cmd.clear_write ? clr_ff : rd_addr;
   assign wr_row   = cmd.clear_write ? row_type'('0) : row_in;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_row;
      rd_ff <= mem[rd_addr];
   end

   // Bucket thresholds: bit k is set exactly when latency >= NS_PER_US << k,
   // that is, when the bit length of latency/1000 exceeds k
   assign lat    = 64'(req_ff.latency);
   assign lat_nz = |req_ff.latency;

   always_comb begin
      for (int k = 0; k < TW; k++) begin
         therm_in[k] = (lat >= (NS_PER_US << k));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) therm_ff <= therm_in;
   end

   // Thermometer to bucket number
   always_comb begin
      bkt_in = '0;
      for (int k = 0; k < TW; k++) begin
         if (therm_ff[k]) bkt_in = BW'(k + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.bin) bkt_ff <= bkt_in;
   end

   // Interface row update
   always_comb begin
      base = rd_ff.present ? rd_ff : row_type'('0);
      row_in         = base;
      row_in.present = 1'b1;
      row_in.packets = base.packets + 64'd1;
      row_in.bytes   = base.bytes + 64'(req_ff.packet_length);
      if (lat_nz) row_in.lat_sum = base.lat_sum + lat;
      if (!rd_ff.present) begin
         row_in.lat_min = lat_nz ? lat : '1;
         row_in.lat_max = lat;
      end else begin
         if (lat_nz && ((lat < rd_ff.lat_min) || (rd_ff.lat_min == '0))) begin
            row_in.lat_min = lat;
         end
         if (lat > rd_ff.lat_max) row_in.lat_max = lat;
      end
      hook = '0;
      case (req_ff.op)
         HOOK_XDP: begin
            row_in.xdp_count = base.xdp_count + 64'd1;
            hook             = row_in.xdp_count;
         end
         HOOK_TC_IN: begin
            row_in.tc_in_count = base.tc_in_count + 64'd1;
            hook               = row_in.tc_in_count;
         end
         HOOK_TC_OUT: begin
            row_in.tc_out_count = base.tc_out_count + 64'd1;
            hook                = row_in.tc_out_count;
         end
         default: hook = '0;
      endcase
   end

   // Histogram and global totals
   assign hist_in = hist_ff[bkt_ff] + 64'(req_ff.matched);
   assign gpkt_in = gpkt_ff + 64'(req_ff.matched);
   assign glat_in = req_ff.matched ? (glat_ff + lat) : glat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BUCKETS; b++) hist_ff[b] <= '0;
         gpkt_ff <= '0;
         glat_ff <= '0;
      end else if (cmd.update) begin
         hist_ff[bkt_ff] <= hist_in;
         gpkt_ff         <= gpkt_in;
         glat_ff         <= glat_in;
      end
   end

   // Result word
   always_comb begin
      rsp_in                  = '0;
      rsp_in.bucket           = 4'(bkt_ff);
      rsp_in.bucket_count     = hist_in;
      rsp_in.all_packet_count = gpkt_in;
      rsp_in.all_latency_sum  = glat_in;
      if (in_range) begin
         rsp_in.if_packet_count  = row_in.packets;
         rsp_in.if_byte_count    = row_in.bytes;
         rsp_in.if_latency_sum   = row_in.lat_sum;
         rsp_in.if_latency_least = row_in.lat_min;
         rsp_in.if_latency_most  = row_in.lat_max;
         rsp_in.if_hook_count    = hook;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* tb/tb_packet_latency_stats_engine.sv */
// Self-checking testbench for the packet latency statistics engine.
module tb_packet_latency_stats_engine;
   import plse_pkg::*;

   localparam int          RANDOM_EVENTS = 1950;
   localparam int          QUIET_TAIL    = 200;
   localparam int          CYCLE_LIMIT   = 100000;
   localparam int          DRAIN_CYCLES  = 8;
   localparam logic [1:0]  HOOK_NONE     = 2'd3;
   localparam logic [47:0] LAT_MAX       = 48'hFFFF_FFFF_FFFF;
   localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

   // One directed row: the event, and a hand-written result where one is given
   typedef struct packed {
      req_type ev;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Shadow copy of the statistics state
   logic        if_seen       [0:255];
   logic [63:0] if_packets    [0:255];
   logic [63:0] if_bytes      [0:255];
   logic [63:0] if_lat_sum    [0:255];
   logic [63:0] if_lat_min    [0:255];
   logic [63:0] if_lat_max    [0:255];
   logic [63:0] if_hook_ctr   [0:255][0:2];
   logic [63:0] hist_count    [0:BUCKETS_DEF-1];
   logic [63:0] total_packets;
   logic [63:0] total_latency;

   rsp_type     pending_results [$];
   dir_row_type directed_rows   [$];

   int errors;
   int results_checked;
   int events_sent;
   int matched_sent;
   int hookless_sent;
   int cycle_total;

   packet_latency_stats_engine dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_total <= cycle_total + 1;
   end

   // Histogram bin: bit length of the latency in whole microseconds, capped
   function automatic logic [3:0] latency_bucket(logic [63:0] ns);
      logic [63:0] us;
      int          n;
      us = ns / NS_PER_US;
      n  = 0;
      while (us != 64'd0) begin
         n++;
         us = us >> 1;
      end
      if (n > BUCKETS_DEF - 1) n = BUCKETS_DEF - 1;
      return n[3:0];
   endfunction

   // Apply one event to the shadow state and return the result it produces
   function automatic rsp_type account_event(req_type ev);
      rsp_type     r;
      logic [3:0]  b;
      logic [63:0] lat;
      int          i;
      r   = '0;
      lat = {16'd0, ev.latency};
      b   = latency_bucket(lat);
      i   = ev.interface_index;
      if (ev.matched) begin
         hist_count[b] = hist_count[b] + 64'd1;
         total_packets = total_packets + 64'd1;
         total_latency = total_latency + lat;
      end
      // first sighting of an interface opens its entry
      if (!if_seen[i]) begin
         if_seen[i]    = 1'b1;
         if_packets[i] = '0;
         if_bytes[i]   = '0;
         if_lat_sum[i] = '0;
         if_lat_min[i] = (lat != 64'd0) ? lat : ALL_ONES;
         if_lat_max[i] = lat;
         for (int h = 0; h < 3; h++) if_hook_ctr[i][h] = '0;
      end
      if_packets[i] = if_packets[i] + 64'd1;
      if_bytes[i]   = if_bytes[i] + {48'd0, ev.packet_length};
      if (lat != 64'd0) begin
         if_lat_sum[i] = if_lat_sum[i] + lat;
         if (lat < if_lat_min[i] || if_lat_min[i] == 64'd0) if_lat_min[i] = lat;
         if (lat > if_lat_max[i]) if_lat_max[i] = lat;
      end
      case (ev.op)
         HOOK_XDP, HOOK_TC_IN, HOOK_TC_OUT: begin
            if_hook_ctr[i][ev.op] = if_hook_ctr[i][ev.op] + 64'd1;
            r.if_hook_count       = if_hook_ctr[i][ev.op];
         end
         default: r.if_hook_count = '0;
      endcase
      r.bucket           = b;
      r.bucket_count     = hist_count[b];
      r.if_packet_count  = if_packets[i];
      r.if_byte_count    = if_bytes[i];
      r.if_latency_sum   = if_lat_sum[i];
      r.if_latency_least = if_lat_min[i];
      r.if_latency_most  = if_lat_max[i];
      r.all_packet_count = total_packets;
      r.all_latency_sum  = total_latency;
      return r;
   endfunction

   // Random event: interfaces crowd onto a few entries, latencies spread over every bin
   function automatic req_type random_event();
      req_type     ev;
      logic [63:0] lat;
      int          sel;
      int          pick;
      pick = $urandom_range(0, 15);
      if (pick < 5)       ev.op = HOOK_XDP;
      else if (pick < 10) ev.op = HOOK_TC_IN;
      else if (pick < 15) ev.op = HOOK_TC_OUT;
      else                ev.op = HOOK_NONE;
      if ($urandom_range(0, 9) < 6) ev.interface_index = 8'($urandom_range(0, 7));
      else                          ev.interface_index = 8'($urandom_range(0, 255));
      ev.packet_length = 16'($urandom_range(0, 65535));
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         lat = '0;
      end else if (sel <= 5) begin
         lat = {$urandom(), $urandom()} >> $urandom_range(14, 63);
      end else if (sel <= 7) begin
         // right on or just under a bin edge
         lat = (NS_PER_US << $urandom_range(0, 15)) - 64'($urandom_range(0, 1));
      end else begin
         lat = {16'($urandom_range(0, 65535)), $urandom()};
      end
      ev.latency = lat[47:0];
      ev.matched = ($urandom_range(0, 3) != 0);
      return ev;
   endfunction

   task automatic add_row(input logic [1:0] op, input logic [7:0] idx, input logic [15:0] len,
                          input logic [47:0] lat, input logic m, input logic typed,
                          input rsp_type want);
      dir_row_type row;
      row.ev.op              = op;
      row.ev.interface_index = idx;
      row.ev.packet_length   = len;
      row.ev.latency         = lat;
      row.ev.matched         = m;
      row.typed              = typed;
      row.want               = want;
      directed_rows.push_back(row);
   endtask

   // Present one word at a falling edge, hold it until taken, record what it should give
   task automatic issue(input req_type ev, input logic typed, input rsp_type want);
      rsp_type predicted;
      start    <= 1'b1;
      req_data <= ev;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predicted = account_event(ev);
      pending_results.push_back(typed ? want : predicted);
      events_sent++;
      if (ev.matched) matched_sent++;
      if (ev.op == HOOK_NONE) hookless_sent++;
      @(negedge clock);
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   // Result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, expected none, got %h", $time, rsp_data);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            compare_field("bucket", {60'd0, want.bucket}, {60'd0, rsp_data.bucket});
            compare_field("bucket_count", want.bucket_count, rsp_data.bucket_count);
            compare_field("if_packet_count", want.if_packet_count, rsp_data.if_packet_count);
            compare_field("if_byte_count", want.if_byte_count, rsp_data.if_byte_count);
            compare_field("if_latency_sum", want.if_latency_sum, rsp_data.if_latency_sum);
            compare_field("if_latency_least", want.if_latency_least,
                          rsp_data.if_latency_least);
            compare_field("if_latency_most", want.if_latency_most, rsp_data.if_latency_most);
            compare_field("if_hook_count", want.if_hook_count, rsp_data.if_hook_count);
            compare_field("all_packet_count", want.all_packet_count,
                          rsp_data.all_packet_count);
            compare_field("all_latency_sum", want.all_latency_sum, rsp_data.all_latency_sum);
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_total < CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_total,
               pending_results.size());
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      rsp_type no_want;
      no_want         = '0;
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      errors          = 0;
      results_checked = 0;
      events_sent     = 0;
      matched_sent    = 0;
      hookless_sent   = 0;
      cycle_total     = 0;
      total_packets   = '0;
      total_latency   = '0;
      for (int i = 0; i < 256; i++) begin
         if_seen[i]    = 1'b0;
         if_packets[i] = '0;
         if_bytes[i]   = '0;
         if_lat_sum[i] = '0;
         if_lat_min[i] = '0;
         if_lat_max[i] = '0;
         for (int h = 0; h < 3; h++) if_hook_ctr[i][h] = '0;
      end
      for (int b = 0; b < BUCKETS_DEF; b++) hist_count[b] = '0;

      // Directed rows. Hand-written results list fields in struct order: bucket,
      // bucket count, if packets, if bytes, if sum, if min, if max, hook count,
      // global packets, global latency.
      // fresh entry, zero latency, unmatched: min reads all ones
      add_row(HOOK_XDP, 8'd0, 16'd0, 48'd0, 1'b0, 1'b1,
              {4'd0, 64'd0, 64'd1, 64'd0, 64'd0, ALL_ONES, 64'd0, 64'd1, 64'd0, 64'd0});
      // index, length and latency at their top values, latency far past the last bin
      add_row(HOOK_TC_IN, 8'd255, 16'hFFFF, LAT_MAX, 1'b1, 1'b1,
              {4'd15, 64'd1, 64'd1, 64'd65535, {16'd0, LAT_MAX}, {16'd0, LAT_MAX},
               {16'd0, LAT_MAX}, 64'd1, 64'd1, {16'd0, LAT_MAX}});
      // unused hook kind, matched with zero latency
      add_row(HOOK_NONE, 8'd128, 16'd1, 48'd0, 1'b1, 1'b1,
              {4'd0, 64'd1, 64'd1, 64'd1, 64'd0, ALL_ONES, 64'd0, 64'd0, 64'd2,
               {16'd0, LAT_MAX}});
      // min replaces the all-ones marker; bin edges
      add_row(HOOK_TC_OUT, 8'd0, 16'hFFFF, 48'd999, 1'b1, 1'b0, no_want);
      add_row(HOOK_XDP, 8'd0, 16'd100, 48'd1000, 1'b0, 1'b0, no_want);
      add_row(HOOK_TC_IN, 8'd0, 16'd200, 48'd1999, 1'b1, 1'b0, no_want);
      add_row(HOOK_TC_OUT, 8'd0, 16'd300, 48'd2000, 1'b1, 1'b0, no_want);
      add_row(HOOK_XDP, 8'd0, 16'd0, 48'd0, 1'b1, 1'b0, no_want);
      add_row(HOOK_XDP, 8'd1, 16'd64, 48'd16383999, 1'b1, 1'b0, no_want);
      add_row(HOOK_TC_IN, 8'd1, 16'd64, 48'd16384000, 1'b1, 1'b0, no_want);
      add_row(HOOK_TC_OUT, 8'd1, 16'd64, 48'd32768000, 1'b0, 1'b0, no_want);
      add_row(HOOK_NONE, 8'd1, 16'd1500, 48'd5000, 1'b1, 1'b0, no_want);
      // new minimum on an entry opened with the largest latency
      add_row(HOOK_XDP, 8'd255, 16'd0, 48'd1, 1'b1, 1'b0, no_want);
      add_row(HOOK_XDP, 8'd255, 16'd0, 48'd500, 1'b1, 1'b0, no_want);
      add_row(HOOK_TC_IN, 8'd2, 16'd9000, 48'h8000_0000_0000, 1'b1, 1'b0, no_want);
      add_row(HOOK_TC_OUT, 8'd2, 16'd60, 48'd1, 1'b0, 1'b0, no_want);
      add_row(HOOK_NONE, 8'd3, 16'd0, 48'd0, 1'b0, 1'b0, no_want);
      // back to back on one entry
      add_row(HOOK_XDP, 8'd3, 16'd40, 48'd7000, 1'b1, 1'b0, no_want);
      add_row(HOOK_XDP, 8'd3, 16'd40, 48'd3000, 1'b1, 1'b0, no_want);
      add_row(HOOK_XDP, 8'd3, 16'd40, 48'd12000, 1'b1, 1'b0, no_want);
      // alternating bit patterns
      add_row(HOOK_TC_OUT, 8'hAA, 16'hAAAA, 48'hAAAA_AAAA_AAAA, 1'b1, 1'b0, no_want);
      add_row(HOOK_TC_IN, 8'h55, 16'h5555, 48'h5555_5555_5555, 1'b0, 1'b0, no_want);

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         issue(directed_rows[k].ev, directed_rows[k].typed, directed_rows[k].want);
      end

      // random traffic; idle bursts in some stretches, none near the end
      for (int k = 0; k < RANDOM_EVENTS; k++) begin
         if (k < RANDOM_EVENTS - QUIET_TAIL && (k / 64) % 3 != 0 &&
             $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         issue(random_event(), 1'b0, no_want);
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d packet events (%0d matched, %0d with no hook kind)", events_sent,
               matched_sent, hookless_sent);
      $display("Checked %0d result words, %0d field mismatches", results_checked, errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* sim.f */
src/plse_pkg.sv
src/plse_ctrl.sv
src/plse_dp.sv
src/packet_latency_stats_engine.sv
tb/tb_packet_latency_stats_engine.sv
